[hdl/integer_to_radix_digits_defines.svh]
// ----------------------------------------------------------------------------
// integer_to_radix_digits assertion macros
// shared assertion forms for the radix digit converter
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define ITRD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itrd assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ITRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itrd assertion failed");

`endif

[hdl/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg
// types, codes and character mapping for the radix digit converter
// ----------------------------------------------------------------------------
package itrd_pkg;

    typedef enum logic [1:0] {
        RADIX_OCT    = 2'd0,
        RADIX_DEC    = 2'd1,
        RADIX_HEX_LO = 2'd2,
        RADIX_HEX_UP = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SHOW
    } state_t;

    // x / 10 == (x * DEC_RECIP) >> DEC_SHIFT for x below 10 * 2**16
    localparam logic [19:0] DEC_RECIP = 20'd838861;
    localparam int          DEC_SHIFT = 23;

    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;

    function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10)
            return ASCII_ZERO + {3'b000, d};
        else
            return base + {3'b000, d} - 7'd10;
    endfunction

endpackage

[hdl/itrd_if.sv]
// ----------------------------------------------------------------------------
// itrd channel interfaces
// valid/ready channels for input numbers and output digits
// ----------------------------------------------------------------------------
interface itrd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  radix_select;
    logic [5:0]  min_digits;

    modport source (output valid, output value, output radix_select, output min_digits,
                    input ready);
    modport sink   (input valid, input value, input radix_select, input min_digits,
                    output ready);
endinterface

interface itrd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

[hdl/integer_to_radix_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// converts an unsigned 64-bit number to ascii digits, most significant first
// ----------------------------------------------------------------------------
// One number is converted at a time; in_ch.ready is high only while the block
// is idle. A small sequencer drives one shared divide-by-radix unit, producing
// digits least significant first into a digit memory. Octal and hex digits are
// produced by a shift; a decimal digit takes one step per slice, because the
// divide-by-ten unit walks the 64-bit value in 16-bit slices with one
// reciprocal multiply per slice. Leading zero padding writes one zero digit per
// step. Each digit is then emitted through two states (S_READ reads the memory,
// S_SHOW presents it on the output), and out_ch.ready can stall the output.
module integer_to_radix_digits #(
    parameter int MAX_DIGITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    itrd_in_if.sink          in_ch,
    itrd_out_if.source       out_ch
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int MW = (CW > 6) ? CW : 6;

    itrd_pkg::state_t state_reg, state_next;
    itrd_pkg::radix_t radix_reg, radix_next;

    logic [63:0]   value_reg, value_next;
    logic [MW-1:0] min_reg, min_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    part_reg, part_next;
    logic          last_reg, last_next;
    logic [3:0]    rd_data_reg;

    logic [3:0]    store_mem [MAX_DIGITS];

    logic          in_acc;
    logic          out_acc;
    logic          done;
    logic          value_zero;
    logic          wr_en;
    logic [3:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count_m1;
    logic [MW-1:0] min_in;

    // decimal slice divider
    logic [5:0]    slice_lsb;
    logic [15:0]   slice;
    logic [19:0]   dec_x;
    logic [39:0]   dec_prod;
    logic [15:0]   dec_q;
    logic [19:0]   dec_r;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_acc  = out_ch.valid && out_ch.ready;
    assign count_m1 = count_reg - CW'(1);
    assign rd_addr  = AW'(count_m1 - emit_idx_reg);
    assign min_in   = (MW'(in_ch.min_digits) > MW'(MAX_DIGITS)) ? MW'(MAX_DIGITS)
                                                                : MW'(in_ch.min_digits);

    // only trusted between digits; mid-digit the remainder sits in part_reg
    assign value_zero = (value_reg == 64'd0) && (phase_reg == 2'd0);

    assign done = (count_reg == CW'(MAX_DIGITS))
               || (value_zero && (count_reg != '0) && (MW'(count_reg) >= min_reg));

    assign slice_lsb = {2'd3 - phase_reg, 4'b0000};
    assign slice     = value_reg[slice_lsb +: 16];
    assign dec_x     = {part_reg, slice};
    assign dec_prod  = dec_x * itrd_pkg::DEC_RECIP;
    assign dec_q     = dec_prod[itrd_pkg::DEC_SHIFT +: 16];
    assign dec_r     = dec_x - {1'b0, dec_q, 3'b000} - {3'b000, dec_q, 1'b0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itrd_pkg::S_IDLE:
            begin
                if (in_acc)
                    state_next = itrd_pkg::S_DIV;
            end
            itrd_pkg::S_DIV:
            begin
                if (done)
                    state_next = itrd_pkg::S_READ;
            end
            itrd_pkg::S_READ:
            begin
                state_next = itrd_pkg::S_SHOW;
            end
            itrd_pkg::S_SHOW:
            begin
                if (out_acc)
                    state_next = last_reg ? itrd_pkg::S_IDLE : itrd_pkg::S_READ;
            end
            default:
            begin
                state_next = itrd_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        value_next    = value_reg;
        radix_next    = radix_reg;
        min_next      = min_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        phase_next    = phase_reg;
        part_next     = part_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_data       = 4'd0;
        in_ch.ready   = 1'b0;
        out_ch.valid  = 1'b0;
        unique case (state_reg)
            itrd_pkg::S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_acc)
                begin
                    value_next    = in_ch.value;
                    radix_next    = itrd_pkg::radix_t'(in_ch.radix_select);
                    min_next      = min_in;
                    count_next    = '0;
                    emit_idx_next = '0;
                    phase_next    = 2'd0;
                    part_next     = 4'd0;
                end
            end
            itrd_pkg::S_DIV:
            begin
                if (!done)
                begin
                    if (value_zero)
                    begin
                        // padding digit
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        case (radix_reg)
                            itrd_pkg::RADIX_OCT:
                            begin
                                wr_en      = 1'b1;
                                wr_data    = {1'b0, value_reg[2:0]};
                                value_next = value_reg >> 3;
                                count_next = count_reg + CW'(1);
                            end
                            itrd_pkg::RADIX_DEC:
                            begin
                                value_next[slice_lsb +: 16] = dec_q;
                                phase_next = phase_reg + 2'd1;
                                part_next  = dec_r[3:0];
                                if (phase_reg == 2'd3)
                                begin
                                    wr_en      = 1'b1;
                                    wr_data    = dec_r[3:0];
                                    part_next  = 4'd0;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                                wr_en      = 1'b1;
                                wr_data    = value_reg[3:0];
                                value_next = value_reg >> 4;
                                count_next = count_reg + CW'(1);
                            end
                        endcase
                    end
                end
            end
            itrd_pkg::S_READ:
            begin
                last_next = (emit_idx_reg == count_m1);
            end
            itrd_pkg::S_SHOW:
            begin
                out_ch.valid = 1'b1;
                if (out_acc)
                    emit_idx_next = emit_idx_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.digit_char = itrd_pkg::digit_to_char(rd_data_reg,
                                                       radix_reg == itrd_pkg::RADIX_HEX_UP);
    assign out_ch.last_digit = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= itrd_pkg::S_IDLE;
            count_reg    <= '0;
            emit_idx_reg <= '0;
            phase_reg    <= 2'd0;
            part_reg     <= 4'd0;
            last_reg     <= 1'b0;
            value_reg    <= 64'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            emit_idx_reg <= emit_idx_next;
            phase_reg    <= phase_next;
            part_reg     <= part_next;
            last_reg     <= last_next;
            value_reg    <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        min_reg   <= min_next;
    end

    // digit memory, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[AW'(count_reg)] <= wr_data;
        if (state_reg == itrd_pkg::S_READ)
            rd_data_reg <= store_mem[rd_addr];
    end

`include "integer_to_radix_digits_defines.svh"

    `ITRD_ASSERT_IMPL(a_no_overlap, in_ch.ready, !out_ch.valid)
    `ITRD_ASSERT_NEXT(a_accept_starts, in_acc, (state_reg == itrd_pkg::S_DIV) && (count_reg == '0))
    `ITRD_ASSERT_IMPL(a_count_bound, state_reg == itrd_pkg::S_DIV,
                      MW'(count_reg) <= MW'(MAX_DIGITS))
    `ITRD_ASSERT_NEXT(a_more_digits, out_acc && !out_ch.last_digit, state_reg == itrd_pkg::S_READ)
    `ITRD_ASSERT_NEXT(a_last_frees, out_acc && out_ch.last_digit, in_ch.ready)

endmodule

[bench/digit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// digit_checker
// watches both channels of the radix digit converter, predicts the ascii
// digits of every accepted number and compares them with the emitted digits
// ----------------------------------------------------------------------------
module digit_checker #(
    parameter int MAX_DIGITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    itrd_in_if   in_ch,
    itrd_out_if  out_ch,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } digit_t;

    localparam string DIGIT_CHARS = "0123456789abcdef";

    digit_t expected_digits[$];
    int     failures = 0;

    assign fail_count = failures;

    task automatic note_failure(input string msg);
        if (failures < 10)
            $display("%0t: %s", $time, msg);
        failures++;
    endtask

    // converts one number and queues its digits, most significant first
    function automatic void predict_digits(input logic [63:0] value,
                                           input itrd_pkg::radix_t sel,
                                           input logic [5:0] min_digits);
        logic [63:0] base;
        logic [63:0] rem;
        int          ndig;
        int          floor_digits;
        logic [3:0]  digs [MAX_DIGITS];
        byte         c;
        digit_t      item;

        case (sel)
            itrd_pkg::RADIX_OCT: base = 64'd8;
            itrd_pkg::RADIX_DEC: base = 64'd10;
            default:             base = 64'd16;
        endcase
        floor_digits = (int'(min_digits) > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits);

        ndig = 0;
        rem  = value;
        if (rem == 64'd0)
            ndig = 1;
        while (rem != 64'd0)
        begin
            rem = rem / base;
            ndig++;
        end
        if (ndig < floor_digits)
            ndig = floor_digits;
        if (ndig > MAX_DIGITS)
            ndig = MAX_DIGITS;

        rem = value;
        for (int i = 0; i < ndig; i++)
        begin
            digs[i] = 4'(rem % base);
            rem     = rem / base;
        end

        for (int i = ndig - 1; i >= 0; i--)
        begin
            c = DIGIT_CHARS[int'(digs[i])];
            if (sel == itrd_pkg::RADIX_HEX_UP && digs[i] >= 4'd10)
                c = c - 8'd32;
            item.ch   = c[6:0];
            item.last = (i == 0);
            expected_digits.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        digit_t got;
        digit_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                predict_digits(in_ch.value, itrd_pkg::radix_t'(in_ch.radix_select),
                               in_ch.min_digits);
            if (out_ch.valid && out_ch.ready)
            begin
                got.ch   = out_ch.digit_char;
                got.last = out_ch.last_digit;
                if (expected_digits.size() == 0)
                    note_failure($sformatf("unexpected digit char=%h last=%b",
                                           got.ch, got.last));
                else
                begin
                    want = expected_digits.pop_front();
                    if (got.ch !== want.ch)
                        note_failure($sformatf("digit_char expected %h actual %h",
                                               want.ch, got.ch));
                    if (got.last !== want.last)
                        note_failure($sformatf("last_digit expected %b actual %b",
                                               want.last, got.last));
                end
            end
        end
        pending <= expected_digits.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives numbers into the radix digit converter under varying idle rates,
// with one long output hold-off; the checker predicts and compares digits
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_DIGITS = 32;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    int   fail_count;
    int   pending;

    itrd_in_if  in_ch();
    itrd_out_if out_ch();

    integer_to_radix_digits #(
        .MAX_DIGITS(MAX_DIGITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    digit_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .fail_count(fail_count),
        .pending(pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // digit receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_number(input logic [63:0] value, input itrd_pkg::radix_t sel,
                               input logic [5:0] min_d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value        <= value;
        in_ch.radix_select <= sel;
        in_ch.min_digits   <= min_d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [63:0] v;
        logic [5:0]  m;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 999));
                2: v = 64'($urandom);
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            // mostly short minimums, some padding, a few above saturation
            pick = $urandom_range(0, 9);
            if (pick < 7)
                m = 6'($urandom_range(0, 8));
            else if (pick < 9)
                m = 6'($urandom_range(9, 32));
            else
                m = 6'($urandom_range(33, 63));
            send_number(v, itrd_pkg::radix_t'($urandom_range(0, 3)), m);
        end
    endtask

    initial
    begin
        in_ch.valid        <= 1'b0;
        in_ch.value        <= '0;
        in_ch.radix_select <= itrd_pkg::RADIX_OCT;
        in_ch.min_digits   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 72;

        // zero, with and without padding, and saturated minimum
        send_number(64'd0, itrd_pkg::RADIX_OCT, 6'd0);
        send_number(64'd0, itrd_pkg::RADIX_DEC, 6'd0);
        send_number(64'd0, itrd_pkg::RADIX_HEX_LO, 6'd1);
        send_number(64'd0, itrd_pkg::RADIX_HEX_UP, 6'd4);
        send_number(64'd0, itrd_pkg::RADIX_DEC, 6'd32);
        send_number(64'd0, itrd_pkg::RADIX_OCT, 6'd63);
        // largest value in every radix
        send_number('1, itrd_pkg::RADIX_OCT, 6'd0);
        send_number('1, itrd_pkg::RADIX_DEC, 6'd0);
        send_number('1, itrd_pkg::RADIX_HEX_LO, 6'd0);
        send_number('1, itrd_pkg::RADIX_HEX_UP, 6'd0);
        send_number('1, itrd_pkg::RADIX_DEC, 6'd33);
        send_number('1, itrd_pkg::RADIX_HEX_UP, 6'd63);
        // all hex letters in both cases
        send_number(64'hfedcba9876543210, itrd_pkg::RADIX_HEX_LO, 6'd0);
        send_number(64'hfedcba9876543210, itrd_pkg::RADIX_HEX_UP, 6'd0);
        send_number(64'h0123456789abcdef, itrd_pkg::RADIX_HEX_UP, 6'd20);
        send_number(64'd1, itrd_pkg::RADIX_DEC, 6'd5);
        send_number(64'd9, itrd_pkg::RADIX_DEC, 6'd0);
        send_number(64'd10, itrd_pkg::RADIX_DEC, 6'd0);
        send_number(64'd8, itrd_pkg::RADIX_OCT, 6'd2);
        send_number(64'd1234567890123456789, itrd_pkg::RADIX_DEC, 6'h2a);
        send_number(64'h8000000000000000, itrd_pkg::RADIX_OCT, 6'h15);
        send_number(64'h5555555555555555, itrd_pkg::RADIX_HEX_LO, 6'h1f);
        // remaining value held only in the top slice with a small quotient
        send_number(64'd14073748835532803, itrd_pkg::RADIX_DEC, 6'd0);
        send_number(64'h0005000000000000, itrd_pkg::RADIX_DEC, 6'd0);

        send_random(28);

        send_idle_pct = 72;
        recv_idle_pct = 23;
        send_random(26);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        send_random(22);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
